>>> hdl/euler_to_quaternion_macros.svh
// Assertion macros used by the checker file
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define E2Q_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define E2Q_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Constants and types for the Euler-angle to quaternion pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package e2q_pkg;

  localparam int CordicStages = 16;
  localparam int AtanEntries  = 24;
  localparam int NumStages    = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;

  // angles at 2^28 scale, x/y at 2^30 scale
  localparam int AngW = 32;
  localparam int XyW  = 33;

  localparam logic signed [AngW-1:0] AngPi     = 32'sd843314857;
  localparam logic signed [AngW-1:0] AngHalfPi = 32'sd421657428;
  localparam logic signed [XyW-1:0]  InvGain   = 33'sd652032874;
  localparam logic signed [15:0]     Q14One    = 16'sd16384;

  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [XyW-1:0]  xy_t;
  typedef logic signed [17:0]     fac_t;

  // CORDIC rotation triple for one angle
  typedef struct packed {
    xy_t  x;
    xy_t  y;
    ang_t z;
  } rot_t;

  function automatic ang_t atan_lut(input logic [4:0] idx);
    ang_t v;
    unique case (idx)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4193963;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Z-Y-X Euler angles (Q3.12 radians) to a unit quaternion (Q1.14, saturated).
// ----------------------------------------------------------------------------
// One item enters per cycle while the pipeline advances. The stages are one fold
// stage, one CORDIC stage per iteration (16), one factor rounding stage, two product
// stages and one rounding/saturation stage which is the output register. The
// whole pipeline advances when the output is empty or being taken; a stall
// freezes every stage in place.
`timescale 1ns / 1ps

module euler_to_quaternion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_yaw_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z
);

  localparam int N = e2q_pkg::NumStages;
  localparam int Lat = N + 5;

  logic adv;
  logic [Lat-1:0] vld_r;

  // stall everything when the output holds an untaken item
  assign adv      = !vld_r[Lat-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  // fold stage: half angle at 2^28 scale, bring into [-pi/2, pi/2]
  e2q_pkg::rot_t  rot_r [3][N+1];
  logic           flip_r [3][N+1];
  logic signed [15:0] ang_in [3];

  assign ang_in[0] = in_roll_angle;
  assign ang_in[1] = in_pitch_angle;
  assign ang_in[2] = in_yaw_angle;

  for (genvar a = 0; a < 3; a++) begin : g_ang
    e2q_pkg::ang_t z0;
    assign z0 = e2q_pkg::ang_t'({{1{ang_in[a][15]}}, ang_in[a], 15'd0});

    always_ff @(posedge clk) begin
      if (adv) begin
        rot_r[a][0].x <= e2q_pkg::InvGain;
        rot_r[a][0].y <= '0;
        if (z0 > e2q_pkg::AngHalfPi) begin
          rot_r[a][0].z <= z0 - e2q_pkg::AngPi;
          flip_r[a][0]  <= 1'b1;
        end else if (z0 < -e2q_pkg::AngHalfPi) begin
          rot_r[a][0].z <= z0 + e2q_pkg::AngPi;
          flip_r[a][0]  <= 1'b1;
        end else begin
          rot_r[a][0].z <= z0;
          flip_r[a][0]  <= 1'b0;
        end
      end
    end

    // one CORDIC micro-rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_cs
      e2q_pkg::xy_t dx, dy;
      e2q_pkg::ang_t at;
      assign dx = rot_r[a][i].y >>> i;
      assign dy = rot_r[a][i].x >>> i;
      assign at = e2q_pkg::atan_lut(5'(i));
      always_ff @(posedge clk) begin
        if (adv) begin
          flip_r[a][i+1] <= flip_r[a][i];
          if (!rot_r[a][i].z[e2q_pkg::AngW-1]) begin
            rot_r[a][i+1].x <= rot_r[a][i].x - dx;
            rot_r[a][i+1].y <= rot_r[a][i].y + dy;
            rot_r[a][i+1].z <= rot_r[a][i].z - at;
          end else begin
            rot_r[a][i+1].x <= rot_r[a][i].x + dx;
            rot_r[a][i+1].y <= rot_r[a][i].y - dy;
            rot_r[a][i+1].z <= rot_r[a][i].z + at;
          end
        end
      end
    end
  end

  // round cos and sin to 2^16 scale, apply the quadrant flip
  e2q_pkg::fac_t c_r [3];
  e2q_pkg::fac_t s_r [3];

  for (genvar a = 0; a < 3; a++) begin : g_fac
    e2q_pkg::xy_t xf, yf, xr, yr;
    assign xf = flip_r[a][N] ? -rot_r[a][N].x : rot_r[a][N].x;
    assign yf = flip_r[a][N] ? -rot_r[a][N].y : rot_r[a][N].y;
    assign xr = (xf + e2q_pkg::xy_t'(8192)) >>> 14;
    assign yr = (yf + e2q_pkg::xy_t'(8192)) >>> 14;
    always_ff @(posedge clk) begin
      if (adv) begin
        c_r[a] <= e2q_pkg::fac_t'(xr);
        s_r[a] <= e2q_pkg::fac_t'(yr);
      end
    end
  end

  // first products: roll-pitch pairs, carry yaw factors along
  logic signed [35:0] cc_r, ss_r, sc_r, cs_r;
  e2q_pkg::fac_t cy_r, sy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      cc_r <= c_r[0] * c_r[1];
      ss_r <= s_r[0] * s_r[1];
      sc_r <= s_r[0] * c_r[1];
      cs_r <= c_r[0] * s_r[1];
      cy_r <= c_r[2];
      sy_r <= s_r[2];
    end
  end

  // second products and sums at 2^48 scale
  logic signed [54:0] w_r, x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r <= 55'(cc_r * cy_r) + 55'(ss_r * sy_r);
      x_r <= 55'(sc_r * cy_r) - 55'(cs_r * sy_r);
      y_r <= 55'(cs_r * cy_r) + 55'(sc_r * sy_r);
      z_r <= 55'(cc_r * sy_r) - 55'(ss_r * cy_r);
    end
  end

  // round half up to Q1.14 and saturate
  function automatic logic signed [15:0] to_q14(input logic signed [54:0] s);
    logic signed [54:0] r;
    r = (s + (55'sd1 <<< 33)) >>> 34;
    if (r > 55'sd16384) return e2q_pkg::Q14One;
    if (r < -55'sd16384) return -e2q_pkg::Q14One;
    return 16'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_quat_w <= to_q14(w_r);
      out_quat_x <= to_q14(x_r);
      out_quat_y <= to_q14(y_r);
      out_quat_z <= to_q14(z_r);
    end
  end

endmodule

>>> hdl/e2q_checker.sv
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks for the Euler to quaternion pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_to_quaternion_macros.svh"

module e2q_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_quat_w,
  input logic signed [15:0] out_quat_x,
  input logic signed [15:0] out_quat_y,
  input logic signed [15:0] out_quat_z
);

  // hold a stalled result: valid and the w component stay
  `E2Q_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_quat_w))
  // never stall input while output is free
  `E2Q_ASSERT_IMP(a_in_ready, clk, rst_n, !out_valid || out_ready, in_ready)
  // w and x results stay within unit range
  `E2Q_ASSERT_IMP(a_w_rng, clk, rst_n, out_valid, out_quat_w <= 16'sd16384 && out_quat_w >= -16'sd16384)
  `E2Q_ASSERT_IMP(a_x_rng, clk, rst_n, out_valid, out_quat_x <= 16'sd16384 && out_quat_x >= -16'sd16384)

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);
